[hdl/pli_pkg.sv]
`default_nettype none
package pli_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int DIV_CNT_W  = $clog2(DATA_WIDTH);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BELOW = 2'd1,
    STAT_ABOVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK0,
    ST_SCAN,
    ST_DIFF,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[hdl/pli_table.sv]
`default_nettype none
module pli_table import pli_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire data_t         wr_x,
  input  wire data_t         wr_y,
  input  wire logic [AW-1:0] rd_addr,
  output data_t              rd_x,
  output data_t              rd_y
);

  logic [2*DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [2*DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we && (32'(wr_addr) < DEPTH)) begin
      mem_r[wr_addr] <= {wr_x, wr_y};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_x = data_t'(rd_data_r[2*DATA_WIDTH-1:DATA_WIDTH]);
  assign rd_y = data_t'(rd_data_r[DATA_WIDTH-1:0]);

endmodule
`default_nettype wire

[hdl/pli_div.sv]
`default_nettype none
module pli_div import pli_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [2*DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0]   divisor,
  output logic      [DATA_WIDTH-1:0]   quotient,
  output div_stat_t                    stat
);

  // restoring division, one quotient bit a cycle; high half is below divisor
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r, done_r;
  logic [DATA_WIDTH:0]   shifted, trial;
  logic                  ge;

  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign ge      = !trial[DATA_WIDTH];
  assign rem_nxt = ge ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
  assign quo_nxt = {quo_r[DATA_WIDTH-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DATA_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[2*DATA_WIDTH-1:DATA_WIDTH];
      quo_r <= dividend[DATA_WIDTH-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

[hdl/piecewise_linear_interp.sv]
// Piecewise linear interpolation over a table of up to MAX_POINTS signed
// Q16.16 breakpoints held in a small RAM. A write item (cmd 0) stores one
// breakpoint and gives no result. A query item (cmd 1) scans the segments
// one table read a cycle; for a query inside the table it subtracts,
// multiplies once and then runs a bit-serial divider one quotient bit a
// cycle, unless the segment has zero width. The length of a query is set by
// the segment scan and the 32-step divider, and the block holds in_stall
// high throughout. A finished result waits in the output register while the
// next item is taken. num_points is clamped to 2..MAX_POINTS when written.
`default_nettype none
module piecewise_linear_interp import pli_pkg::*; #(
  parameter  int MAX_POINTS = 16,
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_cmd,
  input  wire logic [IDX_W-1:0] in_entry_index,
  input  wire data_t            in_entry_x,
  input  wire data_t            in_entry_y,
  input  wire data_t            in_query_x,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output data_t                 out_value,
  output logic      [1:0]       out_status,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int DW = DATA_WIDTH;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       num_points_r;
  logic [IDX_W-1:0]       idx_r;
  data_t                  q_r, x0_r, y0_r, x1_r, y1_r;
  logic [DW-1:0]          dx_r, w_r, mag_r;
  logic                   neg_r, zero_w_r;
  logic [2*DW-1:0]        prod_r;
  status_t                status_r;
  logic                   out_valid_r;
  data_t                  out_value_r;
  status_t                out_status_r;

  logic                   tbl_we, div_start;
  logic [IDX_W-1:0]       rd_addr;
  data_t                  rd_x, rd_y;
  logic [DW-1:0]          div_quo;
  div_stat_t              div_stat;

  logic [DW:0]            cmp_diff, dx_w, w_w, dy_w, dy_neg;
  logic                   q_lt_x, q_le_x;
  logic [CNT_W-1:0]       idx_inc;
  logic                   more_seg;
  logic [DW-1:0]          quo_mag;
  logic [DW+1:0]          quo_s, sum;
  logic                   sat_hi, sat_lo;
  data_t                  fin_value;
  logic                   out_load;
  logic [CNT_W-1:0]       cfg_clamped;

  pli_table #(.DEPTH(MAX_POINTS), .AW(IDX_W)) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .wr_addr (in_entry_index),
    .wr_x    (in_entry_x),
    .wr_y    (in_entry_y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (w_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // shared comparator: table x against the query
  assign cmp_diff = {rd_x[DW-1], rd_x} - {q_r[DW-1], q_r};
  assign q_le_x   = !cmp_diff[DW];
  assign q_lt_x   = q_le_x && (cmp_diff != '0);

  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
  assign more_seg = idx_inc < num_points_r;

  assign dx_w   = {q_r[DW-1], q_r} - {x0_r[DW-1], x0_r};
  assign w_w    = {x1_r[DW-1], x1_r} - {x0_r[DW-1], x0_r};
  assign dy_w   = {y1_r[DW-1], y1_r} - {y0_r[DW-1], y0_r};
  assign dy_neg = -dy_w;

  assign quo_mag   = zero_w_r ? '0 : div_quo;
  assign quo_s     = neg_r ? -{2'b00, quo_mag} : {2'b00, quo_mag};
  assign sum       = {{2{y0_r[DW-1]}}, y0_r} + quo_s;
  assign sat_hi    = !sum[DW+1] && (sum[DW:DW-1] != 2'b00);
  assign sat_lo    = sum[DW+1] && (sum[DW:DW-1] != 2'b11);
  assign fin_value = sat_hi ? data_t'({1'b0, {(DW-1){1'b1}}}) :
                     sat_lo ? data_t'({1'b1, {(DW-1){1'b0}}}) :
                     data_t'(sum[DW-1:0]);

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign cfg_clamped = (cfg_wdata < CNT_W'(2))          ? CNT_W'(2) :
                       (cfg_wdata > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) :
                       cfg_wdata;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_cmd == CMD_QUERY)) state_nxt = ST_CHK0;
      end
      ST_CHK0: begin
        state_nxt = q_lt_x ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (q_le_x) state_nxt = ST_DIFF;
        else if (!more_seg) state_nxt = ST_FIN;
      end
      ST_DIFF:      state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = zero_w_r ? ST_FIN : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    tbl_we    = 1'b0;
    rd_addr   = idx_inc[IDX_W-1:0];
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        tbl_we   = in_valid && (in_cmd == CMD_WRITE);
        rd_addr  = '0;
      end
      ST_DIV_START: div_start = !zero_w_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_points_r <= CNT_W'(2);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) num_points_r <= cfg_clamped;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        q_r   <= in_query_x;
        idx_r <= '0;
      end
      ST_CHK0: begin
        x0_r     <= rd_x;
        y0_r     <= rd_y;
        idx_r    <= idx_inc[IDX_W-1:0];
        status_r <= STAT_BELOW;
      end
      ST_SCAN: begin
        if (q_le_x) begin
          x1_r     <= rd_x;
          y1_r     <= rd_y;
          status_r <= STAT_OK;
        end else begin
          x0_r     <= rd_x;
          y0_r     <= rd_y;
          idx_r    <= idx_inc[IDX_W-1:0];
          status_r <= STAT_ABOVE;
        end
      end
      ST_DIFF: begin
        dx_r     <= dx_w[DW-1:0];
        w_r      <= w_w[DW-1:0];
        zero_w_r <= (w_w[DW-1:0] == '0);
        neg_r    <= dy_w[DW];
        mag_r    <= dy_w[DW] ? dy_neg[DW-1:0] : dy_w[DW-1:0];
      end
      ST_MUL: begin
        prod_r <= dx_r * mag_r;
      end
      ST_FIN: begin
        if (out_load) begin
          out_status_r <= status_r;
          out_value_r  <= (status_r == STAT_OK) ? fin_value : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result appeared without a finished query");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_value_r == '0))
    else $error("error result carries a non-zero value");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(idx_r) < num_points_r))
    else $error("segment scan ran past the table");

endmodule
`default_nettype wire
